FILE: hdl/dahpq_pkg.sv
`default_nettype none
package dahpq_pkg;
    localparam int CAPACITY     = 1024;
    localparam int MAX_ARITY    = 8;
    localparam int KEY_BITS     = 32;
    localparam int PAYLOAD_BITS = 32;
    localparam int ID_BITS      = 10;
    localparam int ID_COUNT     = 1 << ID_BITS;
    localparam int SLOT_BITS    = $clog2(CAPACITY);
    localparam int CNT_BITS     = $clog2(CAPACITY + 1);
    localparam int AR_BITS      = 4;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_POP    = 2'd1;
    localparam logic [1:0] OP_ERASE  = 2'd2;
    localparam logic [1:0] OP_CHANGE = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_ID    = 2'd3;

    localparam logic [0:0] CFG_ARITY     = 1'd0;
    localparam logic [0:0] CFG_MAX_FIRST = 1'd1;

    typedef struct packed {
        logic [1:0]                     operation;
        logic [ID_BITS-1:0]             item_id;
        logic signed [KEY_BITS-1:0]     key;
        logic signed [PAYLOAD_BITS-1:0] payload;
    } t_request;

    typedef struct packed {
        logic [1:0]                     status;
        logic [10:0]                    entry_count;
        logic                           top_valid;
        logic signed [KEY_BITS-1:0]     top_key;
        logic signed [PAYLOAD_BITS-1:0] top_payload;
        logic [ID_BITS-1:0]             top_id;
    } t_result;
endpackage
`default_nettype wire

FILE: hdl/d_ary_heap_priority_queue.sv
// Each level an entry moves makes the operation longer: going down, every child is read in
// turn; going up, the parent is found by a serial divide. The worst case is an insert at
// arity 2 into 1023 entries.
// Throughput: one request at a time; the next is taken at the edge ending the result strobe.
// Sync active-low reset: count 0, arity 4, min first; then all 1024 present bits are cleared
// (busy high). The result is shown for one cycle; the receiver cannot stall.
`default_nettype none
module d_ary_heap_priority_queue
    import dahpq_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire t_request              i_request,
    output logic                       o_result_valid,
    output t_result                    o_result,
    input  wire logic                  i_cfg_we,
    input  wire logic [0:0]            i_cfg_index,
    input  wire logic [AR_BITS-1:0]    i_cfg_data
);
    localparam int EW = KEY_BITS + PAYLOAD_BITS + ID_BITS;

    localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_ID_RD = 4'd2,
        S_ID_WT = 4'd3, S_SLOT_RD = 4'd4, S_SLOT_WT = 4'd5, S_LAST_WT = 4'd6,
        S_DISPATCH = 4'd7, S_UP_RD = 4'd8, S_UP_WT = 4'd9, S_DN_RD = 4'd10,
        S_DN_WT = 4'd11, S_DN_CMP = 4'd12, S_PLACE = 4'd13, S_TOP_WT = 4'd14,
        S_DONE = 4'd15;

    // slot memory: {key, payload, owner}; id memory: {present, position}
    logic [EW-1:0]        r_slot_mem [CAPACITY];
    logic [SLOT_BITS:0]   r_id_mem   [ID_COUNT];

    logic [3:0]           r_state, n_state;
    logic [AR_BITS-1:0]   r_arity;
    logic                 r_max_first;
    logic [CNT_BITS-1:0]  r_count, n_count;
    logic [ID_BITS-1:0]   r_clr, n_clr;
    t_request             r_req, n_req;
    logic [1:0]           r_status, n_status;

    logic [SLOT_BITS-1:0] r_pos, n_pos;          // hole position
    logic [EW-1:0]        r_ent, n_ent;          // entry being placed
    logic [KEY_BITS-1:0]  r_gone, n_gone;
    logic                 r_pres, n_pres;
    logic [CNT_BITS-1:0]  r_child, n_child;      // current child slot
    logic [CNT_BITS-1:0]  r_last, n_last;
    logic [CNT_BITS-1:0]  r_best, n_best;
    logic [EW-1:0]        r_bent, n_bent;
    logic [AR_BITS-1:0]   eff_arity;

    logic [EW-1:0]        r_slot_q;
    logic [SLOT_BITS:0]   r_id_q;

    // memory port controls
    logic                 s_we, s_re;
    logic [SLOT_BITS-1:0] s_addr;
    logic [EW-1:0]        s_wd;
    logic                 id_we, id_re;
    logic [ID_BITS-1:0]   id_addr;
    logic [SLOT_BITS:0]   id_wd;

    logic                 n_res_valid;
    t_result              n_res;

    function automatic logic better(input logic [KEY_BITS-1:0] a,
                                    input logic [KEY_BITS-1:0] b,
                                    input logic mf);
        logic signed [KEY_BITS-1:0] sa, sb;
        sa = a;
        sb = b;
        return mf ? (sa > sb) : (sa < sb);
    endfunction

    function automatic logic [KEY_BITS-1:0] ekey(input logic [EW-1:0] e);
        return e[EW-1 -: KEY_BITS];
    endfunction

    function automatic logic [ID_BITS-1:0] eown(input logic [EW-1:0] e);
        return e[ID_BITS-1:0];
    endfunction

    always_comb begin
        if (r_arity < 4'd2) eff_arity = 4'd2;
        else if (r_arity > AR_BITS'(MAX_ARITY)) eff_arity = AR_BITS'(MAX_ARITY);
        else eff_arity = r_arity;
    end

    // parent of r_pos: r_par tracks (pos-1)/d, built by a shift-subtract divide
    logic [SLOT_BITS-1:0] r_par, n_par;
    logic [SLOT_BITS-1:0] r_rem, n_rem;

    logic [CNT_BITS+AR_BITS-1:0] first_w;
    assign first_w = r_pos * eff_arity + 1'b1;

    always_ff @(posedge i_clk) begin
        if (s_we) r_slot_mem[s_addr] <= s_wd;
        if (s_re) r_slot_q <= r_slot_mem[s_addr];
        if (id_we) r_id_mem[id_addr] <= id_wd;
        if (id_re) r_id_q <= r_id_mem[id_addr];
    end

    // divider state for parent search
    logic [3:0] r_sub;

    always_comb begin
        n_state = r_state; n_count = r_count; n_clr = r_clr; n_req = r_req;
        n_status = r_status; n_pos = r_pos; n_ent = r_ent; n_gone = r_gone;
        n_pres = r_pres; n_child = r_child; n_last = r_last; n_best = r_best;
        n_bent = r_bent; n_par = r_par; n_rem = r_rem;
        s_we = 1'b0; s_re = 1'b0; s_addr = r_pos; s_wd = r_ent;
        id_we = 1'b0; id_re = 1'b0; id_addr = r_req.item_id; id_wd = {1'b1, r_pos};
        n_res_valid = 1'b0; n_res = '0;
        case (r_state)
            S_CLEAR: begin
                id_we = 1'b1; id_addr = r_clr; id_wd = '0;
                n_clr = r_clr + 1'b1;
                if (r_clr == '1) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) begin
                    n_req = i_request; n_status = ST_OK;
                    n_state = S_ID_RD;
                end
            end
            S_ID_RD: begin
                id_re = 1'b1;
                n_state = S_ID_WT;
            end
            S_ID_WT: begin
                n_pres = r_id_q[SLOT_BITS];
                n_state = S_DONE;
                case (r_req.operation)
                    OP_INSERT: begin
                        if (r_count >= CNT_BITS'(CAPACITY)) n_status = ST_FULL;
                        else if (r_id_q[SLOT_BITS]) n_status = ST_ID;
                        else begin
                            id_we = 1'b1; id_wd = {1'b1, SLOT_BITS'(r_count)};
                            n_count = r_count + 1'b1;
                            n_pos = SLOT_BITS'(r_count);
                            n_ent = {r_req.key, r_req.payload, r_req.item_id};
                            n_state = S_DISPATCH;
                            n_gone = '0; // unused on insert; n_pres marks move up
                            n_pres = 1'b1;
                        end
                    end
                    OP_POP: begin
                        if (r_count == '0) n_status = ST_EMPTY;
                        else begin
                            n_pos = '0; n_state = S_SLOT_RD;
                        end
                    end
                    default: begin
                        if (!r_id_q[SLOT_BITS]) n_status = ST_ID;
                        else begin
                            n_pos = r_id_q[SLOT_BITS-1:0]; n_state = S_SLOT_RD;
                        end
                    end
                endcase
            end
            S_SLOT_RD: begin
                s_re = 1'b1;
                n_state = S_SLOT_WT;
            end
            S_SLOT_WT: begin
                n_gone = ekey(r_slot_q);
                n_bent = r_slot_q;
                if (r_req.operation == OP_CHANGE) begin
                    n_ent = {r_req.key, r_slot_q[EW-KEY_BITS-1:0]};
                    if (better(r_req.key, ekey(r_slot_q), r_max_first)) begin
                        n_pres = 1'b1; n_state = S_DISPATCH;
                    end else if (better(ekey(r_slot_q), r_req.key, r_max_first)) begin
                        n_pres = 1'b0; n_state = S_DISPATCH;
                    end else n_state = S_PLACE;  // equal key: rewrite same data
                end else begin
                    id_we = 1'b1; id_addr = eown(r_slot_q); id_wd = '0;
                    n_count = r_count - 1'b1;
                    if (SLOT_BITS'(r_count - 1'b1) == r_pos) n_state = S_TOP_WT;
                    else begin
                        s_re = 1'b1; s_addr = SLOT_BITS'(r_count - 1'b1);
                        n_state = S_LAST_WT;
                    end
                end
            end
            S_LAST_WT: begin
                n_ent = r_slot_q;
                n_pres = !better(r_gone, ekey(r_slot_q), r_max_first);
                n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                // r_pres: 1 move up, 0 move down
                if (r_pres) begin
                    if (r_pos == '0) n_state = S_PLACE;
                    else begin
                        n_rem = r_pos - 1'b1; n_par = '0;
                        n_state = S_UP_RD;
                    end
                end else begin
                    n_child = CNT_BITS'(first_w);
                    n_best = CNT_BITS'(first_w);
                    if (first_w >= (CNT_BITS+AR_BITS)'(r_count)) n_state = S_PLACE;
                    else begin
                        if (first_w + eff_arity - 1'b1 > (CNT_BITS+AR_BITS)'(r_count - 1'b1))
                            n_last = r_count - 1'b1;
                        else n_last = CNT_BITS'(first_w + eff_arity - 1'b1);
                        n_state = S_DN_RD;
                    end
                end
            end
            S_UP_RD: begin
                // wait for the divide to finish, then read the parent
                if (r_rem < SLOT_BITS'(eff_arity)) begin
                    s_re = 1'b1; s_addr = r_par;
                    n_state = S_UP_WT;
                end
            end
            S_UP_WT: begin
                if (better(ekey(r_ent), ekey(r_slot_q), r_max_first)) begin
                    s_we = 1'b1; s_addr = r_pos; s_wd = r_slot_q;
                    id_we = 1'b1; id_addr = eown(r_slot_q); id_wd = {1'b1, r_pos};
                    n_pos = r_par;
                    n_state = S_DISPATCH;
                end else n_state = S_PLACE;
            end
            S_DN_RD: begin
                s_re = 1'b1; s_addr = SLOT_BITS'(r_child);
                n_state = S_DN_WT;
            end
            S_DN_WT: begin
                if (r_child == r_best || better(ekey(r_slot_q), ekey(r_bent), r_max_first)) begin
                    n_best = r_child; n_bent = r_slot_q;
                end
                if (r_child == r_last) n_state = S_DN_CMP;
                else begin
                    n_child = r_child + 1'b1;
                    n_state = S_DN_RD;
                end
            end
            S_DN_CMP: begin
                if (better(ekey(r_bent), ekey(r_ent), r_max_first)) begin
                    s_we = 1'b1; s_addr = r_pos; s_wd = r_bent;
                    id_we = 1'b1; id_addr = eown(r_bent); id_wd = {1'b1, r_pos};
                    n_pos = SLOT_BITS'(r_best);
                    n_state = S_DISPATCH;
                end else n_state = S_PLACE;
            end
            S_PLACE: begin
                s_we = 1'b1; s_addr = r_pos; s_wd = r_ent;
                id_we = 1'b1; id_addr = eown(r_ent); id_wd = {1'b1, r_pos};
                n_state = S_TOP_WT;
            end
            S_TOP_WT: begin
                s_re = 1'b1; s_addr = '0;
                n_state = S_DONE;
            end
            S_DONE: begin
                n_res_valid = 1'b1;
                n_res.status = r_status;
                n_res.entry_count = 11'(r_count);
                if (r_count != '0) begin
                    n_res.top_valid = 1'b1;
                    n_res.top_key = ekey(r_slot_q);
                    n_res.top_payload = r_slot_q[ID_BITS +: PAYLOAD_BITS];
                    n_res.top_id = eown(r_slot_q);
                end
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        // status-only results still need the top entry
        if (r_state == S_ID_WT && n_state == S_DONE) n_state = S_TOP_WT;
    end

    // chunk size for the parent division: largest k with d*2^k <= rem
    always_ff @(posedge i_clk) begin
        if (r_state == S_DISPATCH) r_sub <= 4'd9;
        else if (r_state == S_UP_RD && r_rem >= SLOT_BITS'(eff_arity)
                 && ((SLOT_BITS+4)'(eff_arity) << r_sub) > (SLOT_BITS+4)'(r_rem))
            r_sub <= r_sub - 1'b1;
    end

    logic r_res_valid;
    t_result r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR; r_count <= '0; r_clr <= '0;
            r_arity <= 4'd4; r_max_first <= 1'b0; r_res_valid <= 1'b0;
        end else begin
            r_state <= n_state; r_count <= n_count; r_clr <= n_clr;
            r_res_valid <= n_res_valid;
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_ARITY) r_arity <= i_cfg_data;
                else r_max_first <= i_cfg_data[0];
            end
        end
        r_req <= n_req; r_status <= n_status; r_pos <= n_pos; r_ent <= n_ent;
        r_gone <= n_gone; r_pres <= n_pres; r_child <= n_child; r_last <= n_last;
        r_best <= n_best; r_bent <= n_bent; r_res <= n_res;
    end

    // the parent step only fires when a full chunk fits
    always_ff @(posedge i_clk) begin
        if (r_state == S_DISPATCH) begin
            r_rem <= n_rem; r_par <= n_par;
        end else if (r_state == S_UP_RD && r_rem >= SLOT_BITS'(eff_arity)) begin
            if (((SLOT_BITS+4)'(eff_arity) << r_sub) <= (SLOT_BITS+4)'(r_rem)) begin
                r_rem <= r_rem - SLOT_BITS'((SLOT_BITS+4)'(eff_arity) << r_sub);
                r_par <= r_par + (SLOT_BITS'(1) << r_sub);
            end
        end
    end

    assign busy = (r_state != S_IDLE);
    assign o_result_valid = r_res_valid;
    assign o_result = r_res;
endmodule
`default_nettype wire

FILE: tb/sv/tb_top.sv
`default_nettype none
module tb_top;
    import dahpq_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE      = 200;

    typedef struct {
        t_request rq;
        bit       chk;
        t_result  want;
    } t_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    t_request              i_request;
    logic                  o_result_valid;
    t_result               o_result;
    logic                  i_cfg_we;
    logic [0:0]            i_cfg_index;
    logic [AR_BITS-1:0]    i_cfg_data;

    // heap shadow state
    logic signed [KEY_BITS-1:0]     hp_key [CAPACITY];
    logic signed [PAYLOAD_BITS-1:0] hp_pay [CAPACITY];
    logic [ID_BITS-1:0]             hp_own [CAPACITY];
    int                             id_slot [ID_COUNT];
    bit                             id_held [ID_COUNT];
    int                             fill;
    logic [AR_BITS-1:0]             arity_reg;
    bit                             max_first_reg;

    t_result  result_q [$];
    t_row     dir_rows [$];
    int       errors;
    int       cycles = 0;
    int       idle_pct;

    d_ary_heap_priority_queue DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_request      (i_request),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit ahead(logic signed [KEY_BITS-1:0] a, logic signed [KEY_BITS-1:0] b);
        return max_first_reg ? (a > b) : (a < b);
    endfunction

    function automatic int fan_out();
        if (arity_reg < 2) return 2;
        if (arity_reg > MAX_ARITY) return MAX_ARITY;
        return int'(arity_reg);
    endfunction

    task automatic place(int s, logic signed [KEY_BITS-1:0] k,
                         logic signed [PAYLOAD_BITS-1:0] p, logic [ID_BITS-1:0] o);
        hp_key[s] = k;
        hp_pay[s] = p;
        hp_own[s] = o;
        id_slot[o] = s;
    endtask

    task automatic sift_up(int s, logic signed [KEY_BITS-1:0] k,
                           logic signed [PAYLOAD_BITS-1:0] p, logic [ID_BITS-1:0] o);
        int par;
        while (s > 0) begin
            par = (s - 1) / fan_out();
            if (!ahead(k, hp_key[par])) break;
            place(s, hp_key[par], hp_pay[par], hp_own[par]);
            s = par;
        end
        place(s, k, p, o);
    endtask

    task automatic sift_down(int s, logic signed [KEY_BITS-1:0] k,
                             logic signed [PAYLOAD_BITS-1:0] p, logic [ID_BITS-1:0] o);
        int d;
        int first;
        int last;
        int best;
        d = fan_out();
        forever begin
            first = s * d + 1;
            if (first >= fill) break;
            last = s * d + d;
            if (last > fill - 1) last = fill - 1;
            best = first;
            for (int c = first + 1; c <= last; c++)
                if (ahead(hp_key[c], hp_key[best])) best = c;
            if (!ahead(hp_key[best], k)) break;
            place(s, hp_key[best], hp_pay[best], hp_own[best]);
            s = best;
        end
        place(s, k, p, o);
    endtask

    task automatic evict(int s);
        int                         tail;
        logic signed [KEY_BITS-1:0] gone;
        tail = fill - 1;
        gone = hp_key[s];
        id_held[hp_own[s]] = 1'b0;
        fill = tail;
        if (s != tail) begin
            if (!ahead(gone, hp_key[tail])) sift_up(s, hp_key[tail], hp_pay[tail], hp_own[tail]);
            else sift_down(s, hp_key[tail], hp_pay[tail], hp_own[tail]);
        end
    endtask

    task automatic heap_apply(input t_request rq, output t_result res);
        int                         s;
        logic signed [KEY_BITS-1:0] old;
        res = '0;
        res.status = ST_OK;
        case (rq.operation)
            OP_INSERT: begin
                if (fill >= CAPACITY) res.status = ST_FULL;
                else if (id_held[rq.item_id]) res.status = ST_ID;
                else begin
                    id_held[rq.item_id] = 1'b1;
                    fill++;
                    sift_up(fill - 1, rq.key, rq.payload, rq.item_id);
                end
            end
            OP_POP: begin
                if (fill == 0) res.status = ST_EMPTY;
                else evict(0);
            end
            OP_ERASE: begin
                if (!id_held[rq.item_id]) res.status = ST_ID;
                else evict(id_slot[rq.item_id]);
            end
            default: begin
                if (!id_held[rq.item_id]) res.status = ST_ID;
                else begin
                    s = id_slot[rq.item_id];
                    old = hp_key[s];
                    if (ahead(rq.key, old)) sift_up(s, rq.key, hp_pay[s], rq.item_id);
                    else if (ahead(old, rq.key)) sift_down(s, rq.key, hp_pay[s], rq.item_id);
                end
            end
        endcase
        res.entry_count = fill[10:0];
        if (fill > 0) begin
            res.top_valid   = 1'b1;
            res.top_key     = hp_key[0];
            res.top_payload = hp_pay[0];
            res.top_id      = hp_own[0];
        end
    endtask

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("ERROR @%0d: %s got %0h want %0h", cycles, what, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("d_ary_heap_priority_queue: mismatch");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            if (result_q.size() == 0) begin
                report("unexpected result", o_result[63:0], '0);
            end else begin
                if (o_result.status != result_q[0].status)
                    report("status", o_result.status, result_q[0].status);
                if (o_result.entry_count != result_q[0].entry_count)
                    report("entry_count", o_result.entry_count, result_q[0].entry_count);
                if (o_result.top_valid != result_q[0].top_valid)
                    report("top_valid", o_result.top_valid, result_q[0].top_valid);
                if (o_result.top_key != result_q[0].top_key)
                    report("top_key", o_result.top_key, result_q[0].top_key);
                if (o_result.top_payload != result_q[0].top_payload)
                    report("top_payload", o_result.top_payload, result_q[0].top_payload);
                if (o_result.top_id != result_q[0].top_id)
                    report("top_id", o_result.top_id, result_q[0].top_id);
                void'(result_q.pop_front());
            end
        end
    end

    task automatic issue(input t_request rq, input bit chk, input t_result want);
        t_result res;
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start     <= 1'b1;
        i_request <= rq;
        do @(posedge i_clk); while (busy);
        heap_apply(rq, res);
        if (chk) begin
            if (res != want) report("predictor vs table", res[63:0], want[63:0]);
            result_q = {result_q, want};
        end else begin
            result_q = {result_q, res};
        end
    endtask

    task automatic send(t_request rq);
        issue(rq, 1'b0, '0);
    endtask

    // hold the write until all expected results have arrived and the block has gone quiet
    task automatic write_reg(logic [0:0] idx, logic [AR_BITS-1:0] val);
        start <= 1'b0;
        @(posedge i_clk);
        while (result_q.size() != 0 || busy) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_ARITY) arity_reg = val;
        else max_first_reg = val[0];
    endtask

    task automatic add_row(logic [1:0] op, int id, logic [31:0] k, logic [31:0] p, bit chk,
                           logic [1:0] st, int cnt, logic [31:0] tk, logic [31:0] tp, int tid);
        t_row r;
        r.rq.operation        = op;
        r.rq.item_id          = id[ID_BITS-1:0];
        r.rq.key              = k;
        r.rq.payload          = p;
        r.chk                 = chk;
        r.want.status         = st;
        r.want.entry_count    = cnt[10:0];
        r.want.top_valid      = (cnt != 0);
        r.want.top_key        = tk;
        r.want.top_payload    = tp;
        r.want.top_id         = tid[ID_BITS-1:0];
        dir_rows = {dir_rows, r};
    endtask

    function automatic t_request pick();
        t_request r;
        int       u;
        int       s;
        u = $urandom_range(0, 99);
        r.item_id = ID_BITS'($urandom_range(0, ID_COUNT - 1));
        r.key     = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 16) - 8;
        r.payload = $urandom;
        if (u < 5) begin
            r.operation = 2'($urandom_range(0, 3));
        end else if (fill == 0 || u < (fill < 40 ? 50 : 25)) begin
            r.operation = OP_INSERT;
        end else if (u < 62) begin
            r.operation = OP_POP;
        end else begin
            s = $urandom_range(0, fill - 1);
            r.item_id = hp_own[s];
            r.operation = (u < 80) ? OP_ERASE : OP_CHANGE;
            if ($urandom_range(0, 4) == 0) r.key = hp_key[s];
        end
        return r;
    endfunction

    task automatic random_run(int n);
        repeat (n) send(pick());
    endtask

    initial begin
        t_request rq;
        errors        = 0;
        fill          = 0;
        arity_reg     = 4;
        max_first_reg = 1'b0;
        idle_pct      = 0;
        for (int i = 0; i < ID_COUNT; i++) id_held[i] = 1'b0;
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_request   <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_ARITY;
        i_cfg_data  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);

        // min first, arity 4 after reset
        add_row(OP_POP,    0,    0, 0, 1, ST_EMPTY, 0, 0, 0, 0);
        add_row(OP_ERASE,  5,    0, 0, 1, ST_ID,    0, 0, 0, 0);
        add_row(OP_CHANGE, 5,    0, 0, 1, ST_ID,    0, 0, 0, 0);
        add_row(OP_INSERT, 0, 32'h7fffffff, 32'h80000000, 1, ST_OK, 1,
                32'h7fffffff, 32'h80000000, 0);
        add_row(OP_INSERT, 1023, 32'h80000000, 32'h7fffffff, 1, ST_OK, 2,
                32'h80000000, 32'h7fffffff, 1023);
        add_row(OP_INSERT, 0, 0, 0, 1, ST_ID, 2, 32'h80000000, 32'h7fffffff, 1023);
        add_row(OP_CHANGE, 1023, 32'h80000000, 0, 1, ST_OK, 2,
                32'h80000000, 32'h7fffffff, 1023);
        add_row(OP_CHANGE, 1023, 32'h7fffffff, 0, 1, ST_OK, 2,
                32'h7fffffff, 32'h7fffffff, 1023);
        add_row(OP_INSERT, 512, 32'hffffffff, 5, 1, ST_OK, 3, 32'hffffffff, 5, 512);
        add_row(OP_CHANGE, 0, 32'h80000000, 0, 1, ST_OK, 3,
                32'h80000000, 32'h80000000, 0);
        add_row(OP_ERASE,  0, 0, 0, 1, ST_OK, 2, 32'hffffffff, 5, 512);
        add_row(OP_POP,    0, 0, 0, 1, ST_OK, 1, 32'h7fffffff, 32'h7fffffff, 1023);
        add_row(OP_POP,    0, 0, 0, 1, ST_OK, 0, 0, 0, 0);
        // equal keys: ties keep the lower child
        for (int i = 1; i <= 6; i++) add_row(OP_INSERT, i, 3, i * 11, 0, 0, 0, 0, 0, 0);
        add_row(OP_CHANGE, 3, 3, 0, 0, 0, 0, 0, 0, 0);
        add_row(OP_CHANGE, 5, 1, 0, 0, 0, 0, 0, 0, 0);
        add_row(OP_CHANGE, 5, 9, 0, 0, 0, 0, 0, 0, 0);
        add_row(OP_ERASE,  2, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(OP_POP,    0, 0, 0, 0, 0, 0, 0, 0, 0);
        foreach (dir_rows[i]) issue(dir_rows[i].rq, dir_rows[i].chk, dir_rows[i].want);

        idle_pct = 21;
        write_reg(CFG_ARITY, 4'd2);
        write_reg(CFG_MAX_FIRST, 4'd1);
        random_run(450);

        // fill to capacity, then push past it
        idle_pct = 87;
        write_reg(CFG_ARITY, 4'hf);
        write_reg(CFG_MAX_FIRST, 4'he);
        for (int i = 0; i < ID_COUNT; i++) begin
            rq.operation = OP_INSERT;
            rq.item_id   = ID_BITS'(i);
            rq.key       = $urandom;
            rq.payload   = $urandom;
            send(rq);
        end
        rq.operation = OP_INSERT;
        rq.item_id   = ID_BITS'($urandom_range(0, ID_COUNT - 1));
        send(rq);
        random_run(60);

        idle_pct = 0;
        write_reg(CFG_ARITY, 4'd0);
        write_reg(CFG_MAX_FIRST, 4'd1);
        random_run(150);
        write_reg(CFG_ARITY, 4'd3);
        random_run(100);
        write_reg(CFG_ARITY, 4'd8);
        write_reg(CFG_MAX_FIRST, 4'd0);
        random_run(100);

        start <= 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (errors == 0) $display("d_ary_heap_priority_queue: match");
        else $display("d_ary_heap_priority_queue: mismatch");
        $finish;
    end
endmodule
`default_nettype wire
